### src/tch_pkg.sv
// tch_pkg: shared constants, types and helper functions of the tilt-compensated heading block
// no dependencies; imported by every module under src

package tch_pkg;

  // angle format and cordic depth
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int TAB_LEN         = 24;
  localparam int NSTAGE          = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // datapath widths
  localparam int AW = ANGLE_FRAC_BITS + 3;  // signed angle, a few turns of headroom
  localparam int VW = 50;                   // vectoring datapath
  localparam int RW = 33;                   // rotation datapath, Q30

  localparam logic signed [AW-1:0] A_TURN     = AW'(longint'(1) << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] A_HALF     = AW'(longint'(1) << (ANGLE_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] A_QUARTER  = AW'(longint'(1) << (ANGLE_FRAC_BITS - 2));
  localparam logic signed [AW-1:0] A_3QUARTER = AW'(longint'(3) << (ANGLE_FRAC_BITS - 2));

  localparam logic signed [RW-1:0] INV_GAIN_Q30 = RW'(652032874);
  localparam int CENTI_TURN = 36000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // word fields that ride alongside the cordic pipelines
  typedef struct packed {
    logic                 deg;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
    logic signed [15:0]   mx;
    logic signed [15:0]   my;
    logic signed [15:0]   mz;
    logic [31:0]          r;
    logic signed [RW-1:0] cr;
    logic signed [RW-1:0] sr;
  } tch_side_t;

  // table entry rounded half up to the angle format
  function automatic logic signed [AW-1:0] step_angle(int i);
    logic [32:0] e;
    e = {1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ANGLE_FRAC_BITS));
    return $signed(AW'(e >> (32 - ANGLE_FRAC_BITS)));
  endfunction

  // left shift that brings the larger magnitude to at least 2^30
  function automatic logic [4:0] norm_shift(logic [VW-1:0] m);
    logic [4:0] s;
    s = '0;
    if (m[VW-1:30] == '0) begin
      for (int b = 0; b < 30; b++) begin
        if (m[b]) s = 5'(30 - b);
      end
    end
    return s;
  endfunction

endpackage

### src/tch_sqrt.sv
// tch_sqrt: pipelined floor square root of sum * 2^32, one result bit per stage
// depends on tch_pkg

module tch_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        sum_i,
  input  tch_pkg::tch_side_t side_i,
  output logic               valid_o,
  output logic [31:0]        root_o,
  output tch_pkg::tch_side_t side_o
);
  import tch_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [31:0] sum;
    tch_side_t   side;
  } sq_t;

  sq_t              stg_d [DEPTH];
  sq_t              stg_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  // one radicand digit pair per stage; the low 32 radicand bits are zero
  always_comb begin
    sq_t        src;
    logic [1:0] pair;
    logic [35:0] temp;
    logic [35:0] trial;
    for (int j = 0; j < DEPTH; j++) begin
      if (j == 0) begin
        src.rem  = '0;
        src.root = '0;
        src.sum  = sum_i;
        src.side = side_i;
      end else begin
        src = stg_q[j-1];
      end
      if (DEPTH - 1 - j >= 16) pair = src.sum[2*(DEPTH-1-j-16) +: 2];
      else pair = 2'b00;
      temp  = {src.rem, pair};
      trial = {2'b00, src.root, 2'b01};
      stg_d[j] = src;
      if (temp >= trial) begin
        stg_d[j].rem  = 34'(temp - trial);
        stg_d[j].root = {src.root[30:0], 1'b1};
      end else begin
        stg_d[j].rem  = temp[33:0];
        stg_d[j].root = {src.root[30:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) stg_q <= stg_d;
  end

  assign valid_o = vld_q[DEPTH-1];
  assign root_o  = stg_q[DEPTH-1].root;
  assign side_o  = stg_q[DEPTH-1].side;

endmodule

### src/tch_vec_cordic.sv
// tch_vec_cordic: pipelined vectoring cordic giving atan2(y, x) in turns
// depends on tch_pkg

module tch_vec_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [tch_pkg::VW-1:0] x_i,
  input  logic signed [tch_pkg::VW-1:0] y_i,
  input  tch_pkg::tch_side_t            side_i,
  output logic                          valid_o,
  output logic signed [tch_pkg::AW-1:0] z_o,
  output tch_pkg::tch_side_t            side_o
);
  import tch_pkg::*;

  localparam int DEPTH = NSTAGE + 3;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] z;
    logic [VW-1:0]        m;
    logic [4:0]           sh;
    logic                 zero;
    tch_side_t            side;
  } vec_t;

  vec_t             stg_d [DEPTH];
  vec_t             stg_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  always_comb begin
    logic signed [VW-1:0] xp;
    logic signed [VW-1:0] yp;
    logic [VW-1:0]        ya;
    // fold the left half plane onto the right one
    if (x_i < 0) begin
      xp = -x_i;
      yp = -y_i;
      stg_d[0].z = A_HALF;
    end else begin
      xp = x_i;
      yp = y_i;
      stg_d[0].z = '0;
    end
    ya = (yp < 0) ? $unsigned(-yp) : $unsigned(yp);
    stg_d[0].x    = xp;
    stg_d[0].y    = yp;
    stg_d[0].m    = (ya > $unsigned(xp)) ? ya : $unsigned(xp);
    stg_d[0].zero = (stg_d[0].m == '0);
    stg_d[0].sh   = '0;
    stg_d[0].side = side_i;

    // normalize shift count
    stg_d[1]    = stg_q[0];
    stg_d[1].sh = norm_shift(stg_q[0].m);

    // normalize
    stg_d[2]   = stg_q[1];
    stg_d[2].x = stg_q[1].x <<< stg_q[1].sh;
    stg_d[2].y = stg_q[1].y <<< stg_q[1].sh;

    // micro-rotations drive y toward zero
    for (int j = 0; j < NSTAGE; j++) begin
      stg_d[j+3] = stg_q[j+2];
      if (stg_q[j+2].y < 0) begin
        stg_d[j+3].x = stg_q[j+2].x - (stg_q[j+2].y >>> j);
        stg_d[j+3].y = stg_q[j+2].y + (stg_q[j+2].x >>> j);
        stg_d[j+3].z = stg_q[j+2].z - step_angle(j);
      end else begin
        stg_d[j+3].x = stg_q[j+2].x + (stg_q[j+2].y >>> j);
        stg_d[j+3].y = stg_q[j+2].y - (stg_q[j+2].x >>> j);
        stg_d[j+3].z = stg_q[j+2].z + step_angle(j);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) stg_q <= stg_d;
  end

  // a zero vector gives angle zero
  assign valid_o = vld_q[DEPTH-1];
  assign z_o     = stg_q[DEPTH-1].zero ? '0 : stg_q[DEPTH-1].z;
  assign side_o  = stg_q[DEPTH-1].side;

endmodule

### src/tch_rot_cordic.sv
// tch_rot_cordic: pipelined rotation cordic giving Q30 cosine and sine of an angle in turns
// depends on tch_pkg

module tch_rot_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [tch_pkg::AW-1:0] ang_i,
  input  tch_pkg::tch_side_t            side_i,
  output logic                          valid_o,
  output logic signed [tch_pkg::RW-1:0] cos_o,
  output logic signed [tch_pkg::RW-1:0] sin_o,
  output tch_pkg::tch_side_t            side_o
);
  import tch_pkg::*;

  localparam int DEPTH = NSTAGE + 2;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [AW-1:0] t;
    logic                 neg;
    tch_side_t            side;
  } rot_t;

  rot_t             stg_d [DEPTH];
  rot_t             stg_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  always_comb begin
    logic signed [AW-1:0] t;
    // reduce to [-1/4, 1/4) turn
    t = $signed({3'b000, ang_i[ANGLE_FRAC_BITS-1:0]});
    stg_d[0].neg = 1'b0;
    if (t >= A_QUARTER && t < A_3QUARTER) begin
      t = t - A_HALF;
      stg_d[0].neg = 1'b1;
    end else if (t >= A_3QUARTER) begin
      t = t - A_TURN;
    end
    stg_d[0].t    = t;
    stg_d[0].x    = INV_GAIN_Q30;
    stg_d[0].y    = '0;
    stg_d[0].side = side_i;

    // micro-rotations drive the residual angle toward zero
    for (int j = 0; j < NSTAGE; j++) begin
      stg_d[j+1] = stg_q[j];
      if (stg_q[j].t >= 0) begin
        stg_d[j+1].x = stg_q[j].x - (stg_q[j].y >>> j);
        stg_d[j+1].y = stg_q[j].y + (stg_q[j].x >>> j);
        stg_d[j+1].t = stg_q[j].t - step_angle(j);
      end else begin
        stg_d[j+1].x = stg_q[j].x + (stg_q[j].y >>> j);
        stg_d[j+1].y = stg_q[j].y - (stg_q[j].x >>> j);
        stg_d[j+1].t = stg_q[j].t + step_angle(j);
      end
    end

    // undo the half-turn fold
    stg_d[DEPTH-1] = stg_q[DEPTH-2];
    if (stg_q[DEPTH-2].neg) begin
      stg_d[DEPTH-1].x = -stg_q[DEPTH-2].x;
      stg_d[DEPTH-1].y = -stg_q[DEPTH-2].y;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) stg_q <= stg_d;
  end

  assign valid_o = vld_q[DEPTH-1];
  assign cos_o   = stg_q[DEPTH-1].x;
  assign sin_o   = stg_q[DEPTH-1].y;
  assign side_o  = stg_q[DEPTH-1].side;

endmodule

### src/tch_level.sv
// tch_level: rotates the magnetometer vector into the horizontal plane, four stages
// depends on tch_pkg

module tch_level (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [tch_pkg::RW-1:0] cp_i,
  input  logic signed [tch_pkg::RW-1:0] sp_i,
  input  tch_pkg::tch_side_t            side_i,
  output logic                          valid_o,
  output logic signed [tch_pkg::VW-1:0] mxh_o,
  output logic signed [tch_pkg::VW-1:0] myh_o,
  output logic                          deg_o
);
  import tch_pkg::*;

  localparam logic signed [2*RW-1:0] HALF_Q30 = (2*RW)'(64'd1 << 29);

  typedef struct packed {
    logic signed [2*RW-1:0] srsp;
    logic signed [2*RW-1:0] crsp;
    logic signed [RW+15:0]  mxcp;
    logic signed [RW+15:0]  mycr;
    logic signed [RW+15:0]  mzsr;
    logic signed [15:0]     my;
    logic signed [15:0]     mz;
    logic                   deg;
  } l0_t;

  typedef struct packed {
    logic signed [RW-1:0]   srsp;
    logic signed [RW-1:0]   crsp;
    logic signed [RW+15:0]  mxcp;
    logic signed [VW-1:0]   myh;
    logic signed [15:0]     my;
    logic signed [15:0]     mz;
    logic                   deg;
  } l1_t;

  typedef struct packed {
    logic signed [RW+15:0]  mxcp;
    logic signed [RW+15:0]  mysr;
    logic signed [RW+15:0]  mzcr;
    logic signed [VW-1:0]   myh;
    logic                   deg;
  } l2_t;

  typedef struct packed {
    logic signed [VW-1:0]   mxh;
    logic signed [VW-1:0]   myh;
    logic                   deg;
  } l3_t;

  l0_t l0_d, l0_q;
  l1_t l1_d, l1_q;
  l2_t l2_d, l2_q;
  l3_t l3_d, l3_q;
  logic [3:0] vld_q;

  always_comb begin
    // raw products
    l0_d.srsp = side_i.sr * sp_i;
    l0_d.crsp = side_i.cr * sp_i;
    l0_d.mxcp = side_i.mx * cp_i;
    l0_d.mycr = side_i.my * side_i.cr;
    l0_d.mzsr = side_i.mz * side_i.sr;
    l0_d.my   = side_i.my;
    l0_d.mz   = side_i.mz;
    l0_d.deg  = side_i.deg;

    // round Q60 to Q30, finish myh
    l1_d.srsp = RW'((l0_q.srsp + HALF_Q30) >>> 30);
    l1_d.crsp = RW'((l0_q.crsp + HALF_Q30) >>> 30);
    l1_d.mxcp = l0_q.mxcp;
    l1_d.myh  = VW'(l0_q.mycr) - VW'(l0_q.mzsr);
    l1_d.my   = l0_q.my;
    l1_d.mz   = l0_q.mz;
    l1_d.deg  = l0_q.deg;

    // tilt products
    l2_d.mxcp = l1_q.mxcp;
    l2_d.mysr = l1_q.my * l1_q.srsp;
    l2_d.mzcr = l1_q.mz * l1_q.crsp;
    l2_d.myh  = l1_q.myh;
    l2_d.deg  = l1_q.deg;

    // horizontal x component
    l3_d.mxh = VW'(l2_q.mxcp) + VW'(l2_q.mysr) + VW'(l2_q.mzcr);
    l3_d.myh = l2_q.myh;
    l3_d.deg = l2_q.deg;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l0_q <= l0_d;
      l1_q <= l1_d;
      l2_q <= l2_d;
      l3_q <= l3_d;
    end
  end

  assign valid_o = vld_q[3];
  assign mxh_o   = l3_q.mxh;
  assign myh_o   = l3_q.myh;
  assign deg_o   = l3_q.deg;

endmodule

### src/tilt_compensated_heading_top.sv
// datapath: a chain of square root, three vectoring and two rotation cordic pipelines
// throughput: one word per cycle; a stall at the output freezes the whole pipeline
// reset: asynchronous active-low reset clears all valid bits, payload is not reset
// top level of the tilt-compensated heading block; depends on tch_pkg, tch_sqrt,
// tch_vec_cordic, tch_rot_cordic and tch_level

module tilt_compensated_heading_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        heading_centideg_o,
  output logic               degenerate_o
);
  import tch_pkg::*;

  localparam int PW = ANGLE_FRAC_BITS + 16;

  logic en;

  // front stages
  tch_side_t   f0_d;
  tch_side_t   f0_q, f1_q, f2_q;
  logic [31:0] ay2_q, az2_q, sum_q;
  logic        f0_vld_q, f1_vld_q, f2_vld_q;

  // sqrt and roll
  logic                 sq_vld;
  logic [31:0]          sq_root;
  tch_side_t            sq_side, roll_side;
  logic                 roll_vld;
  logic signed [AW-1:0] roll_z;
  tch_side_t            roll_side_o;
  logic                 rr_vld;
  logic signed [RW-1:0] rr_cos, rr_sin;
  tch_side_t            rr_side, pitch_side;

  // pitch
  logic                 pitch_vld;
  logic signed [AW-1:0] pitch_z;
  tch_side_t            pitch_side_o;
  logic signed [VW-1:0] pitch_x, pitch_y;
  logic                 pr_vld;
  logic signed [RW-1:0] pr_cos, pr_sin;
  tch_side_t            pr_side;

  // level and heading
  logic                 lv_vld, lv_deg;
  logic signed [VW-1:0] lv_mxh, lv_myh;
  logic signed [VW-1:0] h0_x_q, h0_y_q;
  logic                 h0_deg_q, h0_vld_q;
  tch_side_t            hd_side_in, hd_side;
  logic                 hd_vld;
  logic signed [AW-1:0] hd_z;
  logic [PW-1:0]        prod_q;
  logic                 h1_deg_q, h1_vld_q;
  logic [PW-1:0]        cd_full;
  logic [15:0]          cd;
  logic [15:0]          heading_q;
  logic                 deg_q, out_vld_q;

  // the pipeline advances unless a finished word is held at the output
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // valid bits of the front (capture, squares, sum) and of the heading stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q  <= 1'b0;
      f1_vld_q  <= 1'b0;
      f2_vld_q  <= 1'b0;
      h0_vld_q  <= 1'b0;
      h1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f0_vld_q  <= in_valid_i;
      f1_vld_q  <= f0_vld_q;
      f2_vld_q  <= f1_vld_q;
      h0_vld_q  <= lv_vld;
      h1_vld_q  <= hd_vld;
      out_vld_q <= h1_vld_q;
    end
  end

  // incoming word with the zero-accel flag
  always_comb begin
    f0_d     = '0;
    f0_d.deg = (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
    f0_d.ax  = accel_x_i;
    f0_d.ay  = accel_y_i;
    f0_d.az  = accel_z_i;
    f0_d.mx  = mag_x_i;
    f0_d.my  = mag_y_i;
    f0_d.mz  = mag_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q     <= f0_d;
      f1_q     <= f0_q;
      ay2_q    <= 32'(f0_q.ay * f0_q.ay);
      az2_q    <= 32'(f0_q.az * f0_q.az);
      f2_q     <= f1_q;
      sum_q    <= ay2_q + az2_q;
    end
  end

  tch_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f2_vld_q),
    .sum_i   (sum_q),
    .side_i  (f2_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // roll angle
  always_comb begin
    roll_side   = sq_side;
    roll_side.r = sq_root;
  end

  tch_vec_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .x_i     (VW'(sq_side.az)),
    .y_i     (VW'(sq_side.ay)),
    .side_i  (roll_side),
    .valid_o (roll_vld),
    .z_o     (roll_z),
    .side_o  (roll_side_o)
  );

  tch_rot_cordic u_roll_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (roll_vld),
    .ang_i   (roll_z),
    .side_i  (roll_side_o),
    .valid_o (rr_vld),
    .cos_o   (rr_cos),
    .sin_o   (rr_sin),
    .side_o  (rr_side)
  );

  // pitch angle from -ax scaled to Q16 against the Q16 root
  always_comb begin
    pitch_side    = rr_side;
    pitch_side.cr = rr_cos;
    pitch_side.sr = rr_sin;
    pitch_x       = VW'(rr_side.r);
    pitch_y       = -(VW'(rr_side.ax) <<< 16);
  end

  tch_vec_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rr_vld),
    .x_i     (pitch_x),
    .y_i     (pitch_y),
    .side_i  (pitch_side),
    .valid_o (pitch_vld),
    .z_o     (pitch_z),
    .side_o  (pitch_side_o)
  );

  tch_rot_cordic u_pitch_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pitch_vld),
    .ang_i   (pitch_z),
    .side_i  (pitch_side_o),
    .valid_o (pr_vld),
    .cos_o   (pr_cos),
    .sin_o   (pr_sin),
    .side_o  (pr_side)
  );

  tch_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_vld),
    .cp_i    (pr_cos),
    .sp_i    (pr_sin),
    .side_i  (pr_side),
    .valid_o (lv_vld),
    .mxh_o   (lv_mxh),
    .myh_o   (lv_myh),
    .deg_o   (lv_deg)
  );

  // heading vector and zero-field detect
  always_ff @(posedge clk_i) begin
    if (en) begin
      h0_x_q   <= lv_mxh;
      h0_y_q   <= -lv_myh;
      h0_deg_q <= lv_deg || ((lv_mxh == '0) && (lv_myh == '0));
    end
  end

  always_comb begin
    hd_side_in     = '0;
    hd_side_in.deg = h0_deg_q;
  end

  tch_vec_cordic u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h0_vld_q),
    .x_i     (h0_x_q),
    .y_i     (h0_y_q),
    .side_i  (hd_side_in),
    .valid_o (hd_vld),
    .z_o     (hd_z),
    .side_o  (hd_side)
  );

  // scale one turn to centidegrees and round
  assign cd_full = prod_q + PW'(longint'(1) << (ANGLE_FRAC_BITS - 1));
  assign cd      = cd_full[PW-1:ANGLE_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= PW'(hd_z[ANGLE_FRAC_BITS-1:0]) * PW'(CENTI_TURN);
      h1_deg_q <= hd_side.deg;
      deg_q    <= h1_deg_q;
      if (h1_deg_q || (cd >= 16'(CENTI_TURN))) heading_q <= '0;
      else heading_q <= cd;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign heading_centideg_o = heading_q;
  assign degenerate_o       = deg_q;

  // checks
  a_stall_only_on_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_centideg_o < 16'd36000))
    else $error("heading out of range");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (heading_centideg_o == '0))
    else $error("degenerate word with nonzero heading");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h1_vld_q && out_valid_o && out_stall_i) |=> h1_vld_q)
    else $error("word lost inside pipeline during stall");

endmodule
